// File: rtl/erst_pkg.sv
// Package for the Euler rotate/scale/translate block: types, widths and the
// quarter-wave sine table, built at elaboration. No dependencies.
package erst_pkg;

	localparam int ANGLE_BITS = 12;
	localparam int FRAC_BITS  = 12;
	localparam int VEC_BITS   = 32;
	localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
	localparam int QIDX_W     = ANGLE_BITS - 1;
	localparam int TRIG_W     = FRAC_BITS + 1;
	localparam int ELEM_W     = 16;
	localparam int VQ_W       = VEC_BITS - 4;
	localparam int ASH        = ANGLE_BITS - 2;

	localparam logic [63:0] Q62_ONE     = 64'h4000_0000_0000_0000;
	localparam logic [63:0] Q62_HALF_PI = 64'h6487_ED51_10B4_611A;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef elem_t row_t [0:2];
	typedef row_t mat_t [0:2];
	typedef logic signed [VQ_W-1:0] vq_t;
	typedef vq_t vrow_t [0:2];
	typedef logic [TRIG_W-1:0] qsin_tab_t [0:QUARTER];

	typedef struct packed {
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic signed [31:0] trans_x;
		logic signed [31:0] trans_y;
		logic signed [31:0] trans_z;
		logic [ANGLE_BITS-1:0] angle_x;
		logic [ANGLE_BITS-1:0] angle_y;
		logic [ANGLE_BITS-1:0] angle_z;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
	} in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
	} out_t;

	function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	function automatic logic [63:0] angle_q62(logic [63:0] m);
		logic [127:0] p;
		p = {64'd0, Q62_HALF_PI} * {64'd0, m};
		return p[63+ASH:ASH];
	endfunction

	// Taylor term divisors, odd series (2k)(2k+1), even series (2k-1)(2k)
	function automatic logic [63:0] div_term(logic [63:0] t, int k, logic odd);
		logic [63:0] r;
		r = t;
		case (k)
			1:  r = odd ? t / 64'd6   : t / 64'd2;
			2:  r = odd ? t / 64'd20  : t / 64'd12;
			3:  r = odd ? t / 64'd42  : t / 64'd30;
			4:  r = odd ? t / 64'd72  : t / 64'd56;
			5:  r = odd ? t / 64'd110 : t / 64'd90;
			6:  r = odd ? t / 64'd156 : t / 64'd132;
			7:  r = odd ? t / 64'd210 : t / 64'd182;
			8:  r = odd ? t / 64'd272 : t / 64'd240;
			9:  r = odd ? t / 64'd342 : t / 64'd306;
			10: r = odd ? t / 64'd420 : t / 64'd380;
			11: r = odd ? t / 64'd506 : t / 64'd462;
			default: r = t;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] series(logic [63:0] x, logic odd);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		x2   = mul_q62(x, x);
		term = odd ? x : Q62_ONE;
		sum  = term;
		for (int k = 1; k <= 11; k++) begin
			term = div_term(mul_q62(term, x2), k, odd);
			if (k % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		return sum;
	endfunction

	function automatic qsin_tab_t build_qsin();
		qsin_tab_t t;
		logic [63:0] v;
		for (int m = 0; m <= QUARTER; m++) begin
			if (2 * m <= QUARTER)
				v = series(angle_q62(64'(m)), 1'b1);
			else
				v = series(angle_q62(64'(QUARTER - m)), 1'b0);
			t[m] = v[62-FRAC_BITS+TRIG_W-1:62-FRAC_BITS];
		end
		return t;
	endfunction

	localparam qsin_tab_t QSIN = build_qsin();

endpackage

// File: rtl/erst_if.sv
// Valid/ready channel carrying one payload of in_t or out_t.
// Depends on erst_pkg.
interface erst_in_if import erst_pkg::*; ();
	logic valid;
	logic ready;
	in_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface erst_out_if import erst_pkg::*; ();
	logic valid;
	logic ready;
	out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/erst_trig.sv
// Registered sine/cosine lookup for one angle, Q4.12.
// Depends on erst_pkg (quarter-wave table).
module erst_trig import erst_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [ANGLE_BITS-1:0] angle,
	output elem_t                 sin_s1,
	output elem_t                 cos_s1
);

	function automatic elem_t lookup(logic [ANGLE_BITS-1:0] a);
		logic [1:0]        quad;
		logic [QIDX_W-1:0] r;
		logic [QIDX_W-1:0] idx;
		elem_t             mag;
		quad = a[ANGLE_BITS-1:ANGLE_BITS-2];
		r    = {1'b0, a[ANGLE_BITS-3:0]};
		idx  = quad[0] ? QIDX_W'(QUARTER) - r : r;
		mag  = elem_t'(QSIN[idx]);
		return quad[1] ? -mag : mag;
	endfunction

	logic [ANGLE_BITS-1:0] angle_c;
	assign angle_c = angle + ANGLE_BITS'(QUARTER);

	always_ff @(posedge clk) begin
		if (en) begin
			sin_s1 <= lookup(angle);
			cos_s1 <= lookup(angle_c);
		end
	end

endmodule

// File: rtl/erst_lane.sv
// One output row: rotation row product, row scale and dot with the vector.
// Depends on erst_pkg.
module erst_lane import erst_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  row_t               z_row,
	input  mat_t               y_m,
	input  logic signed [31:0] scale,
	input  mat_t               x_m_s2,
	input  vrow_t              vec_s4,
	output vq_t                dot_s5
);

	row_t               zy_s2;
	row_t               m_s3;
	row_t               sc_s4;
	logic signed [31:0] scale_s2;
	logic signed [31:0] scale_s3;

	logic signed [33:0] zy_acc [0:2];
	logic signed [33:0] m_acc  [0:2];
	logic signed [47:0] sc_p   [0:2];
	logic signed [45:0] dot_acc;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			zy_acc[i] = 34'(z_row[0] * y_m[0][i]) + 34'(z_row[1] * y_m[1][i])
				+ 34'(z_row[2] * y_m[2][i]);
			m_acc[i] = 34'(zy_s2[0] * x_m_s2[0][i]) + 34'(zy_s2[1] * x_m_s2[1][i])
				+ 34'(zy_s2[2] * x_m_s2[2][i]);
			sc_p[i] = 48'(m_s3[i]) * 48'(scale_s3);
		end
		dot_acc = 46'(sc_s4[0]) * 46'(vec_s4[0]) + 46'(sc_s4[1]) * 46'(vec_s4[1])
			+ 46'(sc_s4[2]) * 46'(vec_s4[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				zy_s2[i] <= zy_acc[i][27:12];
				m_s3[i]  <= m_acc[i][27:12];
				sc_s4[i] <= sc_p[i][27:12];
			end
			scale_s2 <= scale;
			scale_s3 <= scale_s2;
			dot_s5   <= dot_acc[39:12];
		end
	end

endmodule

// File: rtl/euler_rotate_scale_translate_vec3.sv
// Top level of the Euler rotate/scale/translate block: trig lookups, three
// row lanes and the output stage. Depends on erst_pkg, erst_if, erst_trig, erst_lane.
//
// One vertex per clock while the output is not stalled. Each transaction passes
// six pipeline stages: sine and cosine lookup, Z*Y row, (Z*Y)*X row, row scale,
// dot product, translation. The first stage loads at the accepting edge. The
// three rows run in separate lanes. The whole pipeline holds while the output
// register is full and not taken, so the input is ready whenever the output
// stage is empty or drains.
module euler_rotate_scale_translate_vec3 import erst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	erst_in_if.sink    in_ch,
	erst_out_if.source out_ch
);

	logic [6:1] v_q;
	logic       en;

	assign en           = ~v_q[6] | out_ch.ready;
	assign in_ch.ready  = en;
	assign out_ch.valid = v_q[6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[5:1], in_ch.valid};
		end
	end

	// sine / cosine per axis
	elem_t sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;

	erst_trig u_trig_x (.clk, .en, .angle(in_ch.data.angle_x), .sin_s1(sx_s1), .cos_s1(cx_s1));
	erst_trig u_trig_y (.clk, .en, .angle(in_ch.data.angle_y), .sin_s1(sy_s1), .cos_s1(cy_s1));
	erst_trig u_trig_z (.clk, .en, .angle(in_ch.data.angle_z), .sin_s1(sz_s1), .cos_s1(cz_s1));

	// vector divided by 16 toward zero
	function automatic vq_t div16(logic signed [31:0] a);
		logic signed [31:0] b;
		b = a + (a[31] ? 32'sd15 : 32'sd0);
		return b[31:4];
	endfunction

	vrow_t              vec_s1, vec_s2, vec_s3, vec_s4;
	logic signed [31:0] trans_s1 [0:2];
	logic signed [31:0] trans_s2 [0:2];
	logic signed [31:0] trans_s3 [0:2];
	logic signed [31:0] trans_s4 [0:2];
	logic signed [31:0] trans_s5 [0:2];
	logic signed [31:0] scale_s1 [0:2];
	elem_t              sx_s2, cx_s2;
	out_t               out_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1[0]   <= div16(in_ch.data.vec_x);
			vec_s1[1]   <= div16(in_ch.data.vec_y);
			vec_s1[2]   <= div16(in_ch.data.vec_z);
			trans_s1[0] <= in_ch.data.trans_x;
			trans_s1[1] <= in_ch.data.trans_y;
			trans_s1[2] <= in_ch.data.trans_z;
			scale_s1[0] <= in_ch.data.scale_x;
			scale_s1[1] <= in_ch.data.scale_y;
			scale_s1[2] <= in_ch.data.scale_z;
			vec_s2      <= vec_s1;
			vec_s3      <= vec_s2;
			vec_s4      <= vec_s3;
			trans_s2    <= trans_s1;
			trans_s3    <= trans_s2;
			trans_s4    <= trans_s3;
			trans_s5    <= trans_s4;
			sx_s2       <= sx_s1;
			cx_s2       <= cx_s1;
		end
	end

	localparam elem_t UNIT = elem_t'(1 << FRAC_BITS);

	mat_t z_m, y_m, x_m_s2;

	always_comb begin
		z_m[0][0] = cz_s1;  z_m[0][1] = '0;   z_m[0][2] = -sz_s1;
		z_m[1][0] = '0;     z_m[1][1] = UNIT; z_m[1][2] = '0;
		z_m[2][0] = sz_s1;  z_m[2][1] = '0;   z_m[2][2] = cz_s1;
		y_m[0][0] = cy_s1;  y_m[0][1] = sy_s1; y_m[0][2] = '0;
		y_m[1][0] = -sy_s1; y_m[1][1] = cy_s1; y_m[1][2] = '0;
		y_m[2][0] = '0;     y_m[2][1] = '0;    y_m[2][2] = UNIT;
		x_m_s2[0][0] = cx_s2; x_m_s2[0][1] = '0;   x_m_s2[0][2] = -sx_s2;
		x_m_s2[1][0] = '0;    x_m_s2[1][1] = UNIT; x_m_s2[1][2] = '0;
		x_m_s2[2][0] = sx_s2; x_m_s2[2][1] = '0;   x_m_s2[2][2] = cx_s2;
	end

	vq_t dot_s5 [0:2];

	for (genvar c = 0; c < 3; c++) begin : g_lane
		erst_lane u_lane (
			.clk,
			.en,
			.z_row  (z_m[c]),
			.y_m    (y_m),
			.scale  (scale_s1[c]),
			.x_m_s2 (x_m_s2),
			.vec_s4 (vec_s4),
			.dot_s5 (dot_s5[c])
		);
	end

	// merge lanes: shift back by 4 and translate, wrapping to 32 bits
	always_ff @(posedge clk) begin
		if (en) begin
			out_s6.out_x <= {dot_s5[0], 4'b0000} + trans_s5[0];
			out_s6.out_y <= {dot_s5[1], 4'b0000} + trans_s5[1];
			out_s6.out_z <= {dot_s5[2], 4'b0000} + trans_s5[2];
		end
	end

	assign out_ch.data = out_s6;

endmodule
